>>> src/pulse_baseline_peak_charge_assert.svh
// assertion macros shared by the pulse baseline/peak/charge modules
// each expects clk and rst in the scope where it is used
`ifndef PULSE_BASELINE_PEAK_CHARGE_ASSERT_SVH
`define PULSE_BASELINE_PEAK_CHARGE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PBPC_ASSERT_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
`define PBPC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define PBPC_ASSERT_IMPLY(lbl, cond, prop, msg)
`define PBPC_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

>>> src/pbpc_pkg.sv
`timescale 1ns / 1ps
package pbpc_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 12;
  localparam int LEN_W = 13;
  localparam int POS_W = $clog2(MAX_SAMPLES);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

  localparam int SHORT_LIMIT = 30;
  localparam int PED_START = 2;
  localparam int PED_CAP = 40;
  localparam int PED_DIV = 5;
  localparam int SIG_GAP = 5;
  localparam int TIME_PER_SAMPLE = 5;

  // pedestal end = n / 5 for n below PED_LIMIT, by reciprocal multiply
  localparam int PED_LIMIT = PED_CAP * PED_DIV;
  localparam int NS_W = $clog2(PED_LIMIT);
  localparam int RECIP_SHIFT = 10;
  localparam int RECIP_MUL = (1 << RECIP_SHIFT) / PED_DIV + 1;
  localparam int RECIP_W = $clog2(RECIP_MUL + 1);
  localparam int PE_W = $clog2(PED_CAP + SIG_GAP + 1);

  localparam int FRAC = 8;
  localparam int CNT_W = $clog2(PED_CAP);
  localparam int PSUM_W = SAMPLE_BITS + CNT_W;
  localparam int BSUM_W = SAMPLE_BITS + POS_W;
  localparam int BCNT_W = POS_W + 1;
  localparam int PROD_A_W = BCNT_W + PSUM_W;
  localparam int PROD_B_W = BSUM_W + CNT_W;
  localparam int DIV_W = PROD_A_W + FRAC;
  localparam int STEP_W = $clog2(DIV_W + 1);

  localparam int BASE_W = SAMPLE_BITS + FRAC;
  localparam int AMP_W = BASE_W + 1;
  localparam int CHG_W = 32;
  localparam int TIME_W = 15;

  typedef enum logic [2:0] {
    S_RUN,
    S_MUL,
    S_SUB,
    S_DIVB,
    S_DIVC
  } ctl_state_t;

  typedef struct packed {
    logic sample;
    logic clear;
    logic mul;
    logic sub;
    logic start_b;
    logic start_c;
    logic load_out;
    logic load_short;
  } pbpc_cmd_t;

  typedef struct packed {
    logic last_pos;
    logic full;
    logic div_done;
  } pbpc_stat_t;

endpackage

>>> src/pbpc_div.sv
`timescale 1ns / 1ps
module pbpc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pbpc_pkg::DIV_W-1:0]   dividend,
  input  logic [pbpc_pkg::CNT_W-1:0]   divisor,
  output logic                         done,
  output logic [pbpc_pkg::DIV_W-1:0]   quotient
);
  import pbpc_pkg::*;

  logic               busy;
  logic [STEP_W-1:0]  steps;
  logic [CNT_W-1:0]   dsr;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   rem_next;
  logic [CNT_W:0]     rem_sh;
  logic [DIV_W-1:0]   quo;
  logic               qbit;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem, quo[DIV_W-1]};
    qbit = rem_sh >= {1'b0, dsr};
    if (qbit) begin
      rem_next = CNT_W'(rem_sh - {1'b0, dsr});
    end else begin
      rem_next = rem_sh[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy <= 1'b1;
      steps <= STEP_W'(DIV_W);
    end else if (busy) begin
      if (steps != '0) begin
        steps <= steps - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy && steps != '0) begin
      quo <= {quo[DIV_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign done = busy && (steps == '0);
  assign quotient = quo;

endmodule

>>> src/pbpc_datapath.sv
`timescale 1ns / 1ps
`include "pulse_baseline_peak_charge_assert.svh"
module pbpc_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pbpc_pkg::LEN_W-1:0]          cfg_wdata,
  input  logic [pbpc_pkg::SAMPLE_BITS-1:0]    adc_sample,
  input  pbpc_pkg::pbpc_cmd_t                 cmd,
  output pbpc_pkg::pbpc_stat_t                stat,
  output logic [pbpc_pkg::BASE_W-1:0]         baseline_q8,
  output logic signed [pbpc_pkg::AMP_W-1:0]   amplitude_q8,
  output logic [pbpc_pkg::CHG_W-1:0]          charge_q8,
  output logic [pbpc_pkg::POS_W-1:0]          peak_index,
  output logic [pbpc_pkg::TIME_W-1:0]         peak_time_half_ns,
  output logic                                short_record
);
  import pbpc_pkg::*;

  logic [LEN_W-1:0]           record_length;
  logic [LEN_W-1:0]           eff_len;
  logic [NS_W+RECIP_W-1:0]    pe_prod;
  logic [PE_W-1:0]            ped_end;
  logic [PE_W-1:0]            sig_start;
  logic                       full;
  logic                       last_pos;

  logic [POS_W-1:0]           position;
  logic [PSUM_W-1:0]          ped_sum;
  logic [CNT_W-1:0]           ped_count;
  logic [SAMPLE_BITS-1:0]     min_sample;
  logic [POS_W-1:0]           min_pos;
  logic [BSUM_W-1:0]          below_sum;
  logic [BCNT_W-1:0]          below_count;

  logic                       in_ped;
  logic                       in_sig;
  logic                       below;
  logic [PSUM_W-1:0]          scaled_x;

  logic [PROD_A_W-1:0]        prod_a;
  logic [PROD_B_W-1:0]        prod_b;
  logic [PROD_A_W-1:0]        num;
  logic [BASE_W-1:0]          bq8;
  logic [DIV_W-1:0]           div_dividend;
  logic                       div_done;
  logic [DIV_W-1:0]           div_quotient;

  // record geometry from the length register, and the last-sample flag
  always_comb begin
    if (record_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (record_length > LEN_W'(MAX_SAMPLES)) begin
      eff_len = LEN_W'(MAX_SAMPLES);
    end else begin
      eff_len = record_length;
    end
    pe_prod = (NS_W+RECIP_W)'(eff_len[NS_W-1:0]) * (NS_W+RECIP_W)'(RECIP_MUL);
    if (eff_len >= LEN_W'(PED_LIMIT)) begin
      ped_end = PE_W'(PED_CAP);
    end else begin
      ped_end = PE_W'(pe_prod >> RECIP_SHIFT);
    end
    sig_start = ped_end + PE_W'(SIG_GAP);
    full = eff_len >= LEN_W'(SHORT_LIMIT);
    last_pos = ({1'b0, position} + 1'b1) >= eff_len;
  end

  always_comb begin
    in_ped = (position >= POS_W'(PED_START)) && (position <= POS_W'(ped_end));
    in_sig = position >= POS_W'(sig_start);
    // exact compare of sample against pedestal mean
    scaled_x = PSUM_W'(adc_sample) * PSUM_W'(ped_count);
    below = scaled_x < ped_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_length <= LEN_RESET;
      position <= '0;
      ped_sum <= '0;
      ped_count <= '0;
      min_sample <= '1;
      min_pos <= '0;
      below_sum <= '0;
      below_count <= '0;
    end else begin
      if (cfg_we) begin
        record_length <= cfg_wdata;
      end
      if (cfg_we || cmd.clear) begin
        position <= '0;
        ped_sum <= '0;
        ped_count <= '0;
        min_sample <= '1;
        min_pos <= '0;
        below_sum <= '0;
        below_count <= '0;
      end else if (cmd.sample) begin
        if (!last_pos) begin
          position <= position + 1'b1;
        end
        if (full) begin
          if (in_ped) begin
            ped_sum <= ped_sum + PSUM_W'(adc_sample);
            ped_count <= ped_count + 1'b1;
          end
          if (in_sig) begin
            if (below) begin
              below_sum <= below_sum + BSUM_W'(adc_sample);
              below_count <= below_count + 1'b1;
            end
            if (position == POS_W'(sig_start) || adc_sample < min_sample) begin
              min_sample <= adc_sample;
              min_pos <= position;
            end
          end
        end
      end
    end
  end

  // charge numerator: below_count*sum - below_sum*count
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_a <= PROD_A_W'(below_count) * PROD_A_W'(ped_sum);
      prod_b <= PROD_B_W'(below_sum) * PROD_B_W'(ped_count);
    end
    if (cmd.sub) begin
      num <= prod_a - PROD_A_W'(prod_b);
    end
    if (cmd.start_c) begin
      bq8 <= (ped_count == '0) ? '0 : div_quotient[BASE_W-1:0];
    end
  end

  assign div_dividend = cmd.start_b ? DIV_W'({ped_sum, {FRAC{1'b0}}})
                                    : {num, {FRAC{1'b0}}};

  pbpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_b || cmd.start_c),
    .dividend (div_dividend),
    .divisor  (ped_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_short) begin
      baseline_q8 <= '0;
      amplitude_q8 <= '0;
      charge_q8 <= '0;
      peak_index <= '0;
      peak_time_half_ns <= '0;
      short_record <= 1'b1;
    end else if (cmd.load_out) begin
      baseline_q8 <= bq8;
      amplitude_q8 <= $signed(AMP_W'(bq8) - AMP_W'({min_sample, {FRAC{1'b0}}}));
      charge_q8 <= (ped_count == '0) ? '0 : div_quotient[CHG_W-1:0];
      peak_index <= min_pos;
      peak_time_half_ns <= TIME_W'(min_pos) * TIME_W'(TIME_PER_SAMPLE);
      short_record <= 1'b0;
    end
  end

  assign stat.last_pos = last_pos;
  assign stat.full = full;
  assign stat.div_done = div_done;

  `PBPC_ASSERT_IMPLY(a_ped_nonzero, cmd.start_b, ped_count != '0, "empty pedestal at division")
  `PBPC_ASSERT_IMPLY(a_num_nonneg, cmd.sub, prod_a >= PROD_A_W'(prod_b), "negative charge term")

endmodule

>>> src/pbpc_ctrl.sv
`timescale 1ns / 1ps
`include "pulse_baseline_peak_charge_assert.svh"
module pbpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pbpc_pkg::pbpc_stat_t  stat,
  output pbpc_pkg::pbpc_cmd_t   cmd
);
  import pbpc_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;
  logic       ready_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    ready_int = 1'b0;
    case (state)
      S_RUN: begin
        // a record end needs a free output register
        ready_int = !(stat.last_pos && out_valid);
        cmd.sample = in_valid && ready_int;
        if (cmd.sample && stat.last_pos) begin
          if (stat.full) begin
            state_next = S_MUL;
          end else begin
            cmd.load_short = 1'b1;
            cmd.clear = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.sub = 1'b1;
        cmd.start_b = 1'b1;
        state_next = S_DIVB;
      end
      S_DIVB: begin
        if (stat.div_done) begin
          cmd.start_c = 1'b1;
          state_next = S_DIVC;
        end
      end
      S_DIVC: begin
        if (stat.div_done) begin
          cmd.load_out = 1'b1;
          cmd.clear = 1'b1;
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out || cmd.load_short) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign in_ready = ready_int;

  `PBPC_ASSERT_IMPLY(a_last_free, in_valid && in_ready && stat.last_pos, !out_valid, "record end overwrites result")
  `PBPC_ASSERT_NEXT(a_result_up, cmd.load_out || cmd.load_short, out_valid, "result not presented")
  `PBPC_ASSERT_IMPLY(a_div_owner, stat.div_done, state == S_DIVB || state == S_DIVC, "divider done outside division")

endmodule

>>> src/pulse_baseline_peak_charge.sv
`timescale 1ns / 1ps
// pulse baseline, peak and charge extraction, one converter sample per request
// input channel: in_valid/in_ready with adc_sample; records are record_length long
// config: cfg_we writes record_length from cfg_wdata and restarts the record
// output channel: out_valid/out_ready, one result per record after its last sample
// throughput: one sample per cycle inside a record
// after the last sample of a record of 30 or more samples, the input stalls
// while the shared bit-serial divider runs twice (baseline, then charge),
// each producing a 39-bit quotient, after a multiply step and a subtract
// step; the result is valid in the cycle after the second division ends
// shorter records give an all-zero result with short_record set in the cycle
// after their last sample, with no extra stall
// a finished result sits in the output register; the next record streams in while
// it waits, and only that record's last sample is held off until out_ready takes it
// reset: record length 1024, position and accumulators cleared, no result pending
module pulse_baseline_peak_charge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pbpc_pkg::LEN_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pbpc_pkg::SAMPLE_BITS-1:0]    adc_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pbpc_pkg::BASE_W-1:0]         baseline_q8,
  output logic signed [pbpc_pkg::AMP_W-1:0]   amplitude_q8,
  output logic [pbpc_pkg::CHG_W-1:0]          charge_q8,
  output logic [pbpc_pkg::POS_W-1:0]          peak_index,
  output logic [pbpc_pkg::TIME_W-1:0]         peak_time_half_ns,
  output logic                                short_record
);
  import pbpc_pkg::*;

  pbpc_cmd_t  cmd;
  pbpc_stat_t stat;

  pbpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pbpc_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .adc_sample        (adc_sample),
    .cmd               (cmd),
    .stat              (stat),
    .baseline_q8       (baseline_q8),
    .amplitude_q8      (amplitude_q8),
    .charge_q8         (charge_q8),
    .peak_index        (peak_index),
    .peak_time_half_ns (peak_time_half_ns),
    .short_record      (short_record)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import pbpc_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int REPORT_MAX = 10;
  localparam int RESET_PART = 20;

  typedef struct packed {
    logic [BASE_W-1:0]        baseline;
    logic signed [AMP_W-1:0]  amplitude;
    logic [CHG_W-1:0]         charge;
    logic [POS_W-1:0]         peak_idx;
    logic [TIME_W-1:0]        peak_time;
    logic                     is_short;
  } pulse_result_t;

  typedef struct {
    bit            is_cfg;
    int            val;
    int            reps;
    bit            typed;
    pulse_result_t res;
  } dir_row_t;

  typedef enum int {SH_PULSE, SH_FLAT, SH_NOISE, SH_STEP, SH_TOGGLE} shape_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [LEN_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [SAMPLE_BITS-1:0]  adc_sample = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [BASE_W-1:0]       baseline_q8;
  logic signed [AMP_W-1:0] amplitude_q8;
  logic [CHG_W-1:0]        charge_q8;
  logic [POS_W-1:0]        peak_index;
  logic [TIME_W-1:0]       peak_time_half_ns;
  logic                    short_record;

  pulse_baseline_peak_charge dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .adc_sample        (adc_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .baseline_q8       (baseline_q8),
    .amplitude_q8      (amplitude_q8),
    .charge_q8         (charge_q8),
    .peak_index        (peak_index),
    .peak_time_half_ns (peak_time_half_ns),
    .short_record      (short_record)
  );

  always #6 clk = ~clk;

  // predicted block state
  logic [LEN_W-1:0]       len_q;
  logic [LEN_W-1:0]       pos_q;
  logic [17:0]            ped_sum;
  logic [5:0]             ped_cnt;
  logic [SAMPLE_BITS-1:0] min_smp;
  logic [POS_W-1:0]       min_pos;
  logic [23:0]            blw_sum;
  logic [12:0]            blw_cnt;

  pulse_result_t result_q[$];
  dir_row_t      dir_rows[$];
  int            fail_cnt = 0;
  int            items_sent = 0;
  int            results_due = 0;
  int            snd_idle = 0;
  int            rcv_idle = 0;
  int            hold_ask = 0;
  int            hold_seen = 0;
  int            hold_left = 0;
  int            quiet_cycles = 0;

  // waveform shape of the record being generated
  shape_t sh_kind;
  int     sh_base, sh_noise, sh_at, sh_w, sh_depth, sh_high;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    if (l == 0) return LEN_W'(1);
    if (l > MAX_SAMPLES) return LEN_W'(MAX_SAMPLES);
    return l;
  endfunction

  function automatic void clear_record();
    pos_q = '0;
    ped_sum = '0;
    ped_cnt = '0;
    min_smp = '1;
    min_pos = '0;
    blw_sum = '0;
    blw_cnt = '0;
  endfunction

  function automatic bit accumulate_sample(input logic [SAMPLE_BITS-1:0] x,
                                           output pulse_result_t r);
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] p;
    bit               full;
    int               pe, ss;
    longint unsigned  cnt, num, bq8, cq8, tq;
    longint           amp;
    p = pos_q;
    n = eff_len(len_q);
    full = (n >= SHORT_LIMIT);
    r = '0;
    if (full) begin
      pe = n / PED_DIV;
      if (pe > PED_CAP) pe = PED_CAP;
      ss = pe + SIG_GAP;
      if (p >= PED_START && p <= pe) begin
        ped_sum = ped_sum + x;
        ped_cnt = ped_cnt + 1'b1;
      end
      if (p >= ss) begin
        // exact below-baseline test, no division
        if (longint'(x) * ped_cnt < longint'(ped_sum)) begin
          blw_sum = blw_sum + x;
          blw_cnt = blw_cnt + 1'b1;
        end
        if (p == ss || x < min_smp) begin
          min_smp = x;
          min_pos = p[POS_W-1:0];
        end
      end
    end
    if (p + 1 < n) begin
      pos_q = p + 1'b1;
      return 0;
    end
    if (!full) begin
      r.is_short = 1'b1;
    end else begin
      cnt = ped_cnt;
      bq8 = 0;
      cq8 = 0;
      if (cnt != 0) begin
        num = longint'(blw_cnt) * ped_sum - longint'(blw_sum) * cnt;
        bq8 = (longint'(ped_sum) << FRAC) / cnt;
        cq8 = (num << FRAC) / cnt;
      end
      amp = longint'(bq8) - (longint'(min_smp) << FRAC);
      tq = longint'(min_pos) * TIME_PER_SAMPLE;
      r.baseline = bq8[BASE_W-1:0];
      r.amplitude = amp[AMP_W-1:0];
      r.charge = cq8[CHG_W-1:0];
      r.peak_idx = min_pos;
      r.peak_time = tq[TIME_W-1:0];
    end
    clear_record();
    return 1;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] shape_sample();
    int v;
    int n;
    int k;
    n = eff_len(len_q);
    if (pos_q == 0) begin
      k = $urandom_range(0, 9);
      sh_noise = 0;
      if (k <= 4) begin
        sh_kind = SH_PULSE;
        sh_base = $urandom_range(64, 4095);
        sh_noise = $urandom_range(0, 8);
        sh_at = $urandom_range(0, n - 1);
        sh_w = $urandom_range(1, 12);
        sh_depth = $urandom_range(1, sh_base);
      end else if (k == 5) begin
        sh_kind = SH_FLAT;
        sh_base = $urandom_range(0, 4095);
      end else if (k == 6) begin
        sh_kind = SH_NOISE;
      end else if (k == 7) begin
        // signal region above the pedestal gives a negative amplitude
        sh_kind = SH_STEP;
        sh_base = $urandom_range(0, 2000);
        sh_high = $urandom_range(sh_base, 4095);
        sh_at = $urandom_range(0, n - 1);
        sh_noise = $urandom_range(0, 4);
      end else if (k == 8) begin
        sh_kind = SH_TOGGLE;
      end else begin
        sh_kind = SH_FLAT;
        sh_base = $urandom_range(0, 1) * 4095;
      end
    end
    case (sh_kind)
      SH_PULSE: begin
        v = sh_base;
        if (pos_q >= sh_at && pos_q < sh_at + sh_w) v = v - sh_depth;
      end
      SH_FLAT: v = sh_base;
      SH_NOISE: v = $urandom_range(0, 4095);
      SH_STEP: v = (pos_q >= sh_at) ? sh_high : sh_base;
      default: v = pos_q[0] ? 4095 : 0;
    endcase
    v = v + int'($urandom_range(0, 2 * sh_noise)) - sh_noise;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_BITS-1:0];
  endfunction

  function automatic void add_row(input bit is_cfg, input int val, input int reps,
                                  input bit typed, input pulse_result_t res);
    dir_row_t row;
    row.is_cfg = is_cfg;
    row.val = val;
    row.reps = reps;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  task automatic send_sample(input bit gen, input logic [SAMPLE_BITS-1:0] fixed_x,
                             input bit typed, input pulse_result_t typed_r);
    logic [SAMPLE_BITS-1:0] x;
    pulse_result_t          r;
    bit                     got;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    x = gen ? shape_sample() : fixed_x;
    in_valid <= 1'b1;
    adc_sample <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = accumulate_sample(x, r);
    items_sent++;
    if (typed) begin
      result_q.push_back(typed_r);
      results_due++;
    end else if (got) begin
      result_q.push_back(r);
      results_due++;
    end
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_length(input int v);
    wait_results();
    // let a running divide finish before the record restarts
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[LEN_W-1:0];
    @(posedge clk);
    len_q = v[LEN_W-1:0];
    clear_record();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_segment(input int len, input int recs, input int extra,
                             input bit hold, input int pause_at);
    int n;
    int total;
    set_length(len);
    n = eff_len(LEN_W'(len));
    total = recs * n + extra;
    for (int k = 0; k < total; k++) begin
      if (k == pause_at) wait_results();
      send_sample(1'b1, '0, 1'b0, '0);
      if (hold && k == 0) hold_ask++;
    end
  endtask

  // receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end
  end

  always @(posedge clk) begin
    pulse_result_t got;
    pulse_result_t want;
    if (!rst && out_valid && out_ready) begin
      got.baseline = baseline_q8;
      got.amplitude = amplitude_q8;
      got.charge = charge_q8;
      got.peak_idx = peak_index;
      got.peak_time = peak_time_half_ns;
      got.is_short = short_record;
      if (result_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("unexpected result: base=%0d amp=%0d chg=%0d idx=%0d time=%0d short=%0d",
                   got.baseline, got.amplitude, got.charge, got.peak_idx, got.peak_time,
                   got.is_short);
      end else begin
        want = result_q.pop_front();
        if (got.baseline !== want.baseline || got.amplitude !== want.amplitude ||
            got.charge !== want.charge || got.peak_idx !== want.peak_idx ||
            got.peak_time !== want.peak_time || got.is_short !== want.is_short) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("mismatch: exp base=%0d amp=%0d chg=%0d idx=%0d time=%0d short=%0d",
                     want.baseline, want.amplitude, want.charge, want.peak_idx,
                     want.peak_time, want.is_short, "\n          got base=%0d amp=%0d",
                     got.baseline, got.amplitude, " chg=%0d idx=%0d time=%0d short=%0d",
                     got.charge, got.peak_idx, got.peak_time, got.is_short);
        end
      end
    end
  end

  // watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    pulse_result_t short_res;
    pulse_result_t full_res;
    int            mode_items;
    int            mode_results;
    int            len;
    int            n;
    int            recs;
    int            extra;
    len_q = LEN_RESET;
    clear_record();
    short_res = '0;
    short_res.is_short = 1'b1;
    // full-scale pedestal with a single zero sample at index 15
    full_res = '0;
    full_res.baseline = 20'd1048320;
    full_res.amplitude = 21'sd1048320;
    full_res.charge = 32'd1048320;
    full_res.peak_idx = POS_W'(15);
    full_res.peak_time = TIME_W'(75);

    // zero length acts as one sample per record
    add_row(1'b1, 0, 0, 1'b0, '0);
    add_row(1'b0, 4095, 1, 1'b1, short_res);
    add_row(1'b0, 0, 1, 1'b1, short_res);
    add_row(1'b1, 1, 0, 1'b0, '0);
    add_row(1'b0, 'h555, 1, 1'b1, short_res);
    add_row(1'b1, 2, 0, 1'b0, '0);
    add_row(1'b0, 'hAAA, 1, 1'b0, '0);
    add_row(1'b0, 'h555, 1, 1'b1, short_res);
    // shortest full record
    add_row(1'b1, 30, 0, 1'b0, '0);
    add_row(1'b0, 4095, 15, 1'b0, '0);
    add_row(1'b0, 0, 1, 1'b0, '0);
    add_row(1'b0, 4095, 14, 1'b1, full_res);

    snd_idle = 29;
    rcv_idle = 59;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // start of a record at the length left by reset, cut off by the first write
    repeat (RESET_PART) send_sample(1'b1, '0, 1'b0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        set_length(dir_rows[i].val);
      end else begin
        for (int k = 0; k < dir_rows[i].reps; k++)
          send_sample(1'b0, SAMPLE_BITS'(dir_rows[i].val),
                      dir_rows[i].typed && k == dir_rows[i].reps - 1, dir_rows[i].res);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          snd_idle = 29;
          rcv_idle = 59;
        end
        1: begin
          snd_idle = 59;
          rcv_idle = 29;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      mode_items = items_sent;
      mode_results = results_due;
      case (mode)
        0: begin
          run_segment(29, 1, 0, 1'b0, -1);
          // receiver holds off while records keep streaming in
          run_segment(30, 2, 7, 1'b1, -1);
        end
        1: begin
          run_segment(0, 6, 0, 1'b0, -1);
          // sender stops mid-record until the output side is empty
          run_segment(31, 1, 12, 1'b0, 35);
        end
        default: begin
          // oversized length, partial record only
          run_segment(8191, 0, 20, 1'b0, -1);
          run_segment(1, 5, 0, 1'b0, -1);
        end
      endcase
      while (items_sent - mode_items < 80 || results_due - mode_results < 6) begin
        case ($urandom_range(0, 9))
          0, 1, 2: len = $urandom_range(0, 29);
          9: len = $urandom_range(81, 160);
          default: len = $urandom_range(30, 80);
        endcase
        n = eff_len(LEN_W'(len));
        recs = (n < SHORT_LIMIT) ? $urandom_range(2, 8) : $urandom_range(1, 2);
        extra = 0;
        // leave a partial record so the next write restarts it
        if (n > 1 && $urandom_range(0, 3) == 0) extra = $urandom_range(1, n - 1);
        run_segment(len, recs, extra, 1'b0, -1);
      end
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
